// File: src/mtg_pkg.sv
// Package for the MT19937 generator: store geometry, recurrence and tempering constants.
// No dependencies; the generator top level and its checker import it.
package mtg_pkg;
	localparam int unsigned STORE_DEPTH = 624;
	localparam int unsigned TWIST_OFFSET = 397;
	localparam int unsigned IDX_W = 10;
	localparam logic [31:0] SEED_RESET = 32'd4357;
	localparam logic [31:0] LCG_MULT = 32'd69069;
	localparam logic [31:0] TWIST_XOR = 32'h9908B0DF;
	localparam logic [31:0] UPPER_MASK = 32'h80000000;
	localparam logic [31:0] LOWER_MASK = 32'h7FFFFFFF;
	localparam logic [31:0] TEMPER_B = 32'h9D2C5680;
	localparam logic [31:0] TEMPER_C = 32'hEFC60000;
	localparam logic [1:0] ADDR_SEED = 2'd0;

	function automatic logic [31:0] temper(input logic [31:0] y_in);
		logic [31:0] y;
		y = y_in ^ (y_in >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		return y ^ (y >> 18);
	endfunction
endpackage

// File: src/mersenne_twister_generator_top.sv
// MT19937 generator top level: 624-word state memory, fill, twist, temper and ranged modulo.
// Depends on mtg_pkg.
//
// Each request returns one 32-bit word. After reset or a seed write the state memory is
// refilled by the x*69069 recurrence, one word per cycle (requests held off; seed reads
// and writes stay open). The first request after a fill, and every 624th after, runs a
// twist over the memory: three reads and one write per word through a single-port
// memory. Otherwise a raw word passes the read, temper and output states before its
// result is valid, and a ranged word adds a bit-serial remainder over the 32 bits of the
// word between temper and output. Ranged requests with equal bounds return range_low and
// consume no word.
// One request is in work at a time; the result sits in an output register.
module mersenne_twister_generator_top import mtg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] range_low, [63:32] range_high
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] value
);
	typedef enum logic [3:0] {
		ST_FILL, ST_IDLE, ST_TW_RD0, ST_TW_RD1, ST_TW_RD2, ST_TW_WR,
		ST_RD, ST_TEMP, ST_MOD, ST_OUT
	} state_t;

	state_t            state_q;
	logic [31:0]       mem [STORE_DEPTH];
	logic [IDX_W-1:0]  mem_addr;
	logic              mem_we;
	logic [31:0]       mem_wdata;
	logic [31:0]       mem_rdata_q;

	logic [31:0]       seed_q;
	logic [31:0]       lcg_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  words_left_q;
	logic [IDX_W-1:0]  read_index_q;
	logic [31:0]       cur_q, nxt_q;
	logic              mode_q;
	logic [31:0]       lo_q, span_q, word_q, rem_q;
	logic [5:0]        bit_q;
	logic              out_valid_q;
	logic [31:0]       out_q;

	logic              seed_wr;
	logic [IDX_W-1:0]  idx_p1, idx_off;
	logic [31:0]       diff, span;
	logic [32:0]       rem_sh;
	logic [31:0]       y;

	assign pready   = 1'b1;
	assign prdata   = (paddr == ADDR_SEED) ? seed_q : '0;
	assign seed_wr  = psel && penable && pwrite && (paddr == ADDR_SEED);
	assign s_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// Neighbor indices modulo the store depth.
	assign idx_p1  = (idx_q == IDX_W'(STORE_DEPTH - 1)) ? '0 : idx_q + 1'b1;
	assign idx_off = (idx_q >= IDX_W'(STORE_DEPTH - TWIST_OFFSET))
		? IDX_W'(idx_q - IDX_W'(STORE_DEPTH - TWIST_OFFSET))
		: IDX_W'(idx_q + IDX_W'(TWIST_OFFSET));

	assign diff   = s_tdata[63:32] - s_tdata[31:0];
	assign span   = diff[31] ? (32'd0 - diff) : diff;
	assign rem_sh = {rem_q, word_q[31]};
	assign y      = (cur_q & UPPER_MASK) | (nxt_q & LOWER_MASK);

	// Single port: address and write enable follow the state.
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = lcg_q;
		mem_addr  = idx_q;
		unique case (state_q)
			ST_FILL: mem_we = 1'b1;
			ST_TW_RD1: mem_addr = idx_p1;
			ST_TW_RD2: mem_addr = idx_off;
			ST_TW_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata_q ^ (y >> 1) ^ (nxt_q[0] ? TWIST_XOR : 32'd0);
			end
			ST_RD: mem_addr = read_index_q;
			default: mem_addr = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		mem_rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;
			seed_q       <= SEED_RESET;
			lcg_q        <= SEED_RESET | 32'd1;
			idx_q        <= '0;
			words_left_q <= '0;
			read_index_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			if (seed_wr) begin
				// Restart the fill from the new seed.
				seed_q       <= pwdata;
				lcg_q        <= pwdata | 32'd1;
				idx_q        <= '0;
				words_left_q <= '0;
				read_index_q <= '0;
				state_q      <= ST_FILL;
			end else begin
				unique case (state_q)
					ST_FILL: begin
						lcg_q <= lcg_q * LCG_MULT;
						if (idx_q == IDX_W'(STORE_DEPTH - 1)) begin
							idx_q   <= '0;
							state_q <= ST_IDLE;
						end else
							idx_q <= idx_q + 1'b1;
					end
					ST_IDLE: begin
						if (s_tvalid && s_tready) begin
							mode_q <= s_tuser;
							lo_q   <= s_tdata[31:0];
							span_q <= span;
							if (s_tuser && s_tdata[31:0] == s_tdata[63:32]) begin
								// Equal bounds: answer low, keep state.
								out_q       <= s_tdata[31:0];
								out_valid_q <= 1'b1;
							end else if (words_left_q == '0) begin
								idx_q   <= '0;
								state_q <= ST_TW_RD0;
							end else begin
								words_left_q <= words_left_q - 1'b1;
								state_q      <= ST_RD;
							end
						end
					end
					ST_TW_RD0: state_q <= ST_TW_RD1;   // addr idx: current word
					ST_TW_RD1: begin                   // addr idx+1
						cur_q   <= mem_rdata_q;
						state_q <= ST_TW_RD2;
					end
					ST_TW_RD2: begin                   // addr idx+offset
						nxt_q   <= mem_rdata_q;
						state_q <= ST_TW_WR;
					end
					ST_TW_WR: begin
						if (idx_q == IDX_W'(STORE_DEPTH - 1)) begin
							words_left_q <= IDX_W'(STORE_DEPTH - 1);
							read_index_q <= '0;
							state_q      <= ST_RD;
						end else begin
							idx_q   <= idx_p1;
							state_q <= ST_TW_RD0;
						end
					end
					ST_RD: begin
						read_index_q <= (read_index_q == IDX_W'(STORE_DEPTH - 1))
							? '0 : read_index_q + 1'b1;
						state_q <= ST_TEMP;
					end
					ST_TEMP: begin
						word_q <= temper(mem_rdata_q);
						rem_q  <= '0;
						bit_q  <= '0;
						state_q <= mode_q ? ST_MOD : ST_OUT;
					end
					ST_MOD: begin
						// Restoring remainder, one bit per cycle.
						rem_q  <= (rem_sh >= {1'b0, span_q}) ? 32'(rem_sh - {1'b0, span_q})
							: rem_sh[31:0];
						bit_q  <= bit_q + 1'b1;
						if (bit_q == 6'd31) begin
							word_q  <= lo_q;
							state_q <= ST_OUT;
						end else
							word_q <= {word_q[30:0], 1'b0};
					end
					ST_OUT: begin
						out_q       <= mode_q ? (word_q + rem_q) : word_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end
endmodule

// File: src/mtg_checker.sv
// Port-level checker for the MT19937 generator, bound to its top level.
// Depends on mtg_pkg.
module mtg_checker import mtg_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("request taken while result waits");
	a_serial: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("second request in work");
	a_rdy: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind mersenne_twister_generator_top mtg_checker u_chk (.*);
